@@ sv/eegp_pkg.sv @@
// Package for the EEG headset packet parser: command transactions between
// front and back, status codes, payload item codes and queue sizing.
// No dependencies.
package eegp_pkg;

  localparam logic [7:0] SYNC_BYTE  = 8'hAA;
  localparam logic [7:0] CSUM_BASE  = 8'hFF;

  // payload item codes
  localparam logic [7:0] CODE_QUAL  = 8'h02;
  localparam logic [7:0] CODE_ATT   = 8'h04;
  localparam logic [7:0] CODE_MED   = 8'h05;
  localparam logic [7:0] CODE_BLINK = 8'h16;
  localparam logic [7:0] CODE_SKIP  = 8'h80;
  localparam logic [7:0] CODE_BANDS = 8'h83;

  // result status
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_CSUM = 2'd1;
  localparam logic [1:0] ST_LEN  = 2'd2;

  // command kinds from front to back
  localparam logic [2:0] CMD_START    = 3'd0;
  localparam logic [2:0] CMD_DATA     = 3'd1;
  localparam logic [2:0] CMD_WALK     = 3'd2;
  localparam logic [2:0] CMD_ERR_CSUM = 3'd3;
  localparam logic [2:0] CMD_ERR_LEN  = 3'd4;

  localparam int NUM_BANDS = 8;
  localparam int QDEPTH    = 4;
  localparam int QAW       = $clog2(QDEPTH);

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] data;
  } cmd_t;

endpackage

@@ sv/eegp_front.sv @@
// Front end of the packet parser: hunts for sync, tracks length, count and
// payload sum, and turns received bytes into command transactions.
// Depends on eegp_pkg.
module eegp_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic [7:0]    in_rx_byte,
  output logic          in_stall,
  input  logic          q_full,
  output logic          q_push,
  output eegp_pkg::cmd_t q_cmd
);
  import eegp_pkg::*;

  localparam logic [2:0] PH_SYNC1 = 3'd0;
  localparam logic [2:0] PH_SYNC2 = 3'd1;
  localparam logic [2:0] PH_LEN   = 3'd2;
  localparam logic [2:0] PH_DATA  = 3'd3;
  localparam logic [2:0] PH_CSUM  = 3'd4;

  logic [2:0] phase_r, phase_nxt;
  logic [7:0] count_r, count_nxt;
  logic [7:0] len_r, len_nxt;
  logic [7:0] sum_r, sum_nxt;
  logic       accept;

  assign in_stall = q_full;
  assign accept   = in_valid & ~q_full;

  always_comb begin
    phase_nxt  = phase_r;
    count_nxt  = count_r;
    len_nxt    = len_r;
    sum_nxt    = sum_r;
    q_push     = 1'b0;
    q_cmd.kind = CMD_DATA;
    q_cmd.data = in_rx_byte;
    if (accept) begin
      unique case (phase_r)
        PH_SYNC2: begin
          phase_nxt = (in_rx_byte == SYNC_BYTE) ? PH_LEN : PH_SYNC1;
        end
        PH_LEN: begin
          phase_nxt = PH_SYNC1;
          if (in_rx_byte == SYNC_BYTE) begin
            // drop silently
          end else if (in_rx_byte > SYNC_BYTE) begin
            q_push     = 1'b1;
            q_cmd.kind = CMD_ERR_LEN;
          end else begin
            q_push     = 1'b1;
            q_cmd.kind = CMD_START;
            len_nxt    = in_rx_byte;
            count_nxt  = 8'd0;
            sum_nxt    = 8'd0;
            phase_nxt  = (in_rx_byte == 8'd0) ? PH_CSUM : PH_DATA;
          end
        end
        PH_DATA: begin
          q_push     = 1'b1;
          q_cmd.kind = CMD_DATA;
          sum_nxt    = sum_r + in_rx_byte;
          count_nxt  = count_r + 8'd1;
          if (count_nxt >= len_r) begin
            phase_nxt = PH_CSUM;
          end
        end
        PH_CSUM: begin
          phase_nxt  = PH_SYNC1;
          q_push     = 1'b1;
          q_cmd.kind = ((CSUM_BASE - sum_r) == in_rx_byte) ? CMD_WALK : CMD_ERR_CSUM;
        end
        default: begin
          phase_nxt = (in_rx_byte == SYNC_BYTE) ? PH_SYNC2 : PH_SYNC1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_SYNC1;
      count_r <= 8'd0;
      len_r   <= 8'd0;
      sum_r   <= 8'd0;
    end else begin
      phase_r <= phase_nxt;
      count_r <= count_nxt;
      len_r   <= len_nxt;
      sum_r   <= sum_nxt;
    end
  end

endmodule

@@ sv/eegp_cmd_fifo.sv @@
// Short command queue between front and back of the packet parser.
// Depends on eegp_pkg.
module eegp_cmd_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  eegp_pkg::cmd_t push_cmd,
  output logic           full,
  input  logic           pop,
  output eegp_pkg::cmd_t pop_cmd,
  output logic           not_empty
);
  import eegp_pkg::*;

  cmd_t           q_r [QDEPTH];
  logic [QAW-1:0] wptr_r, rptr_r;
  logic [QAW:0]   cnt_r, cnt_nxt;
  logic           do_push, do_pop;

  assign full      = (cnt_r == (QAW+1)'(QDEPTH));
  assign not_empty = (cnt_r != '0);
  assign do_push   = push & ~full;
  assign do_pop    = pop & not_empty;
  assign pop_cmd   = q_r[rptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (do_push & ~do_pop) begin
      cnt_nxt = cnt_r + (QAW+1)'(1);
    end else if (do_pop & ~do_push) begin
      cnt_nxt = cnt_r - (QAW+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      q_r[wptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (do_push) wptr_r <= wptr_r + QAW'(1);
      if (do_pop)  rptr_r <= rptr_r + QAW'(1);
      cnt_r <= cnt_nxt;
    end
  end

endmodule

@@ sv/eegp_back.sv @@
// Back end of the packet parser: stores the payload, walks it after a good
// checksum, keeps the latest values and drives the result register.
// Depends on eegp_pkg.
module eegp_back #(
  parameter int PAYLOAD_DEPTH = 256
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_valid,
  input  eegp_pkg::cmd_t q_cmd,
  output logic           q_pop,
  output logic           out_valid,
  input  logic           out_stall,
  output logic [1:0]     out_status,
  output logic [7:0]     out_signal_quality,
  output logic [7:0]     out_attention_level,
  output logic [7:0]     out_meditation_level,
  output logic [7:0]     out_blink_level,
  output logic [2:0]     out_band_index,
  output logic [23:0]    out_band_power,
  output logic           out_last
);
  import eegp_pkg::*;

  localparam int AW = $clog2(PAYLOAD_DEPTH);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_CRD  = 4'd1;
  localparam logic [3:0] S_CODE = 4'd2;
  localparam logic [3:0] S_VRD  = 4'd3;
  localparam logic [3:0] S_VAL  = 4'd4;
  localparam logic [3:0] S_BRD  = 4'd5;
  localparam logic [3:0] S_BYTE = 4'd6;
  localparam logic [3:0] S_EMIT = 4'd7;
  localparam logic [3:0] S_ERR  = 4'd8;

  localparam logic [1:0] TGT_QUAL  = 2'd0;
  localparam logic [1:0] TGT_ATT   = 2'd1;
  localparam logic [1:0] TGT_MED   = 2'd2;
  localparam logic [1:0] TGT_BLINK = 2'd3;

  logic [7:0]  mem [PAYLOAD_DEPTH];
  logic [7:0]  rdata_r;
  logic        inr_r;
  logic [7:0]  byte_v;

  logic [3:0]  state_r, state_nxt;
  logic [7:0]  len_r, len_nxt;
  logic [7:0]  wptr_r, wptr_nxt;
  logic [7:0]  idx_r, idx_nxt;
  logic [1:0]  tgt_r, tgt_nxt;
  logic [1:0]  bcnt_r, bcnt_nxt;
  logic [2:0]  band_r, band_nxt;
  logic [15:0] acc_r, acc_nxt;
  logic [2:0]  k_r, k_nxt;
  logic [1:0]  errst_r, errst_nxt;

  logic [7:0]  qual_r, att_r, med_r, blink_r;
  logic [23:0] bands_r [NUM_BANDS];

  logic        mem_we;
  logic        scal_we;
  logic        band_we;
  logic [23:0] band_word;
  logic        out_room;
  logic        out_load;
  logic [1:0]  ld_status;
  logic [2:0]  ld_index;
  logic [23:0] ld_power;
  logic        ld_last;

  // entries at or past the packet length read as zero
  assign byte_v    = inr_r ? rdata_r : 8'd0;
  assign band_word = {acc_r, byte_v};
  assign out_room  = ~out_valid | ~out_stall;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wptr_r[AW-1:0]] <= q_cmd.data;
    end
    rdata_r <= mem[idx_r[AW-1:0]];
    inr_r   <= (idx_r < len_r);
  end

  always_comb begin
    state_nxt = state_r;
    len_nxt   = len_r;
    wptr_nxt  = wptr_r;
    idx_nxt   = idx_r;
    tgt_nxt   = tgt_r;
    bcnt_nxt  = bcnt_r;
    band_nxt  = band_r;
    acc_nxt   = acc_r;
    k_nxt     = k_r;
    errst_nxt = errst_r;
    q_pop     = 1'b0;
    mem_we    = 1'b0;
    scal_we   = 1'b0;
    band_we   = 1'b0;
    out_load  = 1'b0;
    ld_status = ST_OK;
    ld_index  = k_r;
    ld_power  = bands_r[k_r];
    ld_last   = (k_r == 3'(NUM_BANDS - 1));
    unique case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          unique case (q_cmd.kind)
            CMD_START: begin
              len_nxt  = q_cmd.data;
              wptr_nxt = 8'd0;
            end
            CMD_DATA: begin
              mem_we   = 1'b1;
              wptr_nxt = wptr_r + 8'd1;
            end
            CMD_WALK: begin
              idx_nxt   = 8'd0;
              state_nxt = S_CRD;
            end
            CMD_ERR_CSUM: begin
              errst_nxt = ST_CSUM;
              state_nxt = S_ERR;
            end
            CMD_ERR_LEN: begin
              errst_nxt = ST_LEN;
              state_nxt = S_ERR;
            end
            default: begin
            end
          endcase
        end
      end
      S_CRD: begin
        if (idx_r >= len_r) begin
          k_nxt     = 3'd0;
          state_nxt = S_EMIT;
        end else begin
          state_nxt = S_CODE;
        end
      end
      S_CODE: begin
        unique case (byte_v)
          CODE_QUAL: begin
            tgt_nxt = TGT_QUAL;  idx_nxt = idx_r + 8'd1; state_nxt = S_VRD;
          end
          CODE_ATT: begin
            tgt_nxt = TGT_ATT;   idx_nxt = idx_r + 8'd1; state_nxt = S_VRD;
          end
          CODE_MED: begin
            tgt_nxt = TGT_MED;   idx_nxt = idx_r + 8'd1; state_nxt = S_VRD;
          end
          CODE_BLINK: begin
            tgt_nxt = TGT_BLINK; idx_nxt = idx_r + 8'd1; state_nxt = S_VRD;
          end
          CODE_SKIP: begin
            idx_nxt   = idx_r + 8'd4;
            state_nxt = S_CRD;
          end
          CODE_BANDS: begin
            // skip code and its length byte
            idx_nxt   = idx_r + 8'd2;
            band_nxt  = 3'd0;
            bcnt_nxt  = 2'd0;
            state_nxt = S_BRD;
          end
          default: begin
            idx_nxt   = idx_r + 8'd1;
            state_nxt = S_CRD;
          end
        endcase
      end
      S_VRD: begin
        state_nxt = S_VAL;
      end
      S_VAL: begin
        scal_we   = 1'b1;
        idx_nxt   = idx_r + 8'd1;
        state_nxt = S_CRD;
      end
      S_BRD: begin
        state_nxt = S_BYTE;
      end
      S_BYTE: begin
        idx_nxt = idx_r + 8'd1;
        if (bcnt_r == 2'd2) begin
          band_we  = 1'b1;
          bcnt_nxt = 2'd0;
          band_nxt = band_r + 3'd1;
          state_nxt = (band_r == 3'(NUM_BANDS - 1)) ? S_CRD : S_BRD;
        end else begin
          acc_nxt   = {acc_r[7:0], byte_v};
          bcnt_nxt  = bcnt_r + 2'd1;
          state_nxt = S_BRD;
        end
      end
      S_EMIT: begin
        if (out_room) begin
          out_load = 1'b1;
          k_nxt    = k_r + 3'd1;
          if (ld_last) begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_ERR: begin
        ld_status = errst_r;
        ld_index  = 3'd0;
        ld_power  = 24'd0;
        ld_last   = 1'b1;
        if (out_room) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      len_r   <= 8'd0;
      wptr_r  <= 8'd0;
      idx_r   <= 8'd0;
      tgt_r   <= TGT_QUAL;
      bcnt_r  <= 2'd0;
      band_r  <= 3'd0;
      k_r     <= 3'd0;
      errst_r <= ST_OK;
      qual_r  <= 8'd200;
      att_r   <= 8'd0;
      med_r   <= 8'd0;
      blink_r <= 8'd0;
      for (int i = 0; i < NUM_BANDS; i++) begin
        bands_r[i] <= 24'd0;
      end
      out_valid <= 1'b0;
    end else begin
      state_r <= state_nxt;
      len_r   <= len_nxt;
      wptr_r  <= wptr_nxt;
      idx_r   <= idx_nxt;
      tgt_r   <= tgt_nxt;
      bcnt_r  <= bcnt_nxt;
      band_r  <= band_nxt;
      k_r     <= k_nxt;
      errst_r <= errst_nxt;
      if (scal_we) begin
        unique case (tgt_r)
          TGT_QUAL:  qual_r  <= byte_v;
          TGT_ATT:   att_r   <= byte_v;
          TGT_MED:   med_r   <= byte_v;
          TGT_BLINK: blink_r <= byte_v;
          default:   qual_r  <= byte_v;
        endcase
      end
      if (band_we) begin
        bands_r[band_r] <= band_word;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload of the result register
  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    if (out_load) begin
      out_status           <= ld_status;
      out_signal_quality   <= qual_r;
      out_attention_level  <= att_r;
      out_meditation_level <= med_r;
      out_blink_level      <= blink_r;
      out_band_index       <= ld_index;
      out_band_power       <= ld_power;
      out_last             <= ld_last;
    end
  end

endmodule

@@ sv/eeg_headset_packet_parser.sv @@
// Serial packet parser for an EEG headset byte stream. One received byte is
// taken per cycle while the four-entry command queue has room; the front end
// classifies it (sync, length, payload, checksum) and the back end stores the
// payload in a PAYLOAD_DEPTH x 8 memory. A good checksum starts a walk of that
// memory through its one registered read port, then eight results, one per
// band, leave back to back unless the receiver stalls; a checksum or length
// error gives one result. Byte rate is one per cycle within a packet while
// the queue has room. While a walk runs, the queue holds up to four further
// commands (sync bytes need none), after which the input stalls.
module eeg_headset_packet_parser #(
  parameter int PAYLOAD_DEPTH = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic [7:0]  out_signal_quality,
  output logic [7:0]  out_attention_level,
  output logic [7:0]  out_meditation_level,
  output logic [7:0]  out_blink_level,
  output logic [2:0]  out_band_index,
  output logic [23:0] out_band_power,
  output logic        out_last
);
  import eegp_pkg::*;

  cmd_t push_cmd, pop_cmd;
  logic push, full, pop, not_empty;

  eegp_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_rx_byte (in_rx_byte),
    .in_stall   (in_stall),
    .q_full     (full),
    .q_push     (push),
    .q_cmd      (push_cmd)
  );

  eegp_cmd_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_cmd  (push_cmd),
    .full      (full),
    .pop       (pop),
    .pop_cmd   (pop_cmd),
    .not_empty (not_empty)
  );

  eegp_back #(
    .PAYLOAD_DEPTH (PAYLOAD_DEPTH)
  ) u_back (
    .clk                  (clk),
    .rst_n                (rst_n),
    .q_valid              (not_empty),
    .q_cmd                (pop_cmd),
    .q_pop                (pop),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_status           (out_status),
    .out_signal_quality   (out_signal_quality),
    .out_attention_level  (out_attention_level),
    .out_meditation_level (out_meditation_level),
    .out_blink_level      (out_blink_level),
    .out_band_index       (out_band_index),
    .out_band_power       (out_band_power),
    .out_last             (out_last)
  );

endmodule

@@ sv/eegp_checker.sv @@
// Port-level checks for the EEG headset packet parser, bound to the top level.
// Depends on eegp_pkg.
module eegp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic [7:0]  in_rx_byte,
  input logic        out_valid,
  input logic        out_stall,
  input logic [1:0]  out_status,
  input logic [7:0]  out_signal_quality,
  input logic [7:0]  out_attention_level,
  input logic [7:0]  out_meditation_level,
  input logic [7:0]  out_blink_level,
  input logic [2:0]  out_band_index,
  input logic [23:0] out_band_power,
  input logic        out_last
);
  import eegp_pkg::*;

  // hold a stalled byte
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_rx_byte))
    else $error("stalled byte changed");

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status)
      && $stable(out_signal_quality) && $stable(out_attention_level)
      && $stable(out_meditation_level) && $stable(out_blink_level)
      && $stable(out_band_index) && $stable(out_band_power) && $stable(out_last))
    else $error("stalled result changed");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == ST_OK || out_status == ST_CSUM || out_status == ST_LEN))
    else $error("unknown status");

  a_err_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |-> out_last && out_band_index == 3'd0
      && out_band_power == 24'd0)
    else $error("error result malformed");

  // band results of one packet follow each other without gaps
  a_band_seq: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_last |=>
      out_valid && out_status == ST_OK && out_band_index == $past(out_band_index) + 3'd1)
    else $error("band sequence broken");

endmodule

bind eeg_headset_packet_parser eegp_checker u_eegp_checker (.*);

@@ dv/tb.sv @@
// Testbench for eeg_headset_packet_parser: drives received bytes, predicts the
// per-band or error reports of each packet and checks them as they leave the block.
// Depends on eegp_pkg and the eeg_headset_packet_parser RTL.
module tb;
  import eegp_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int HOLD_CYCLES    = 400;
  localparam int SETTLE_CYCLES  = 600;
  localparam int MAX_LEN        = 169;
  localparam int STAGE_END [3]  = '{160, 300, 430};

  typedef enum logic [2:0] {
    HUNT_SYNC1, HUNT_SYNC2, READ_LEN, READ_DATA, READ_CSUM
  } parse_phase_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  quality;
    logic [7:0]  attention;
    logic [7:0]  meditation;
    logic [7:0]  blink;
    logic [2:0]  band;
    logic [23:0] power;
    logic        last;
  } band_report_t;

  typedef struct packed {
    logic [7:0]   rx;
    logic         has_exp;
    band_report_t exp;
  } stim_row_t;

  localparam band_report_t NO_REPORT  = '0;
  localparam band_report_t LEN_ERR_RST =
    '{ST_LEN, 8'd200, 8'd0, 8'd0, 8'd0, 3'd0, 24'd0, 1'b1};
  localparam band_report_t CSUM_ERR_RST =
    '{ST_CSUM, 8'd200, 8'd0, 8'd0, 8'd0, 3'd0, 24'd0, 1'b1};

  // expected reports are typed in only for the error rows
  localparam stim_row_t DIRECTED [26] = '{
    '{SYNC_BYTE, 1'b0, NO_REPORT}, '{SYNC_BYTE, 1'b0, NO_REPORT},
    '{8'hB0, 1'b1, LEN_ERR_RST},
    '{SYNC_BYTE, 1'b0, NO_REPORT}, '{SYNC_BYTE, 1'b0, NO_REPORT},
    '{SYNC_BYTE, 1'b0, NO_REPORT},
    '{SYNC_BYTE, 1'b0, NO_REPORT}, '{8'h55, 1'b0, NO_REPORT},
    '{SYNC_BYTE, 1'b0, NO_REPORT}, '{SYNC_BYTE, 1'b0, NO_REPORT},
    '{8'h00, 1'b0, NO_REPORT}, '{8'hFF, 1'b0, NO_REPORT},
    '{SYNC_BYTE, 1'b0, NO_REPORT}, '{SYNC_BYTE, 1'b0, NO_REPORT},
    '{8'h00, 1'b0, NO_REPORT}, '{8'h00, 1'b1, CSUM_ERR_RST},
    '{SYNC_BYTE, 1'b0, NO_REPORT}, '{SYNC_BYTE, 1'b0, NO_REPORT},
    '{8'hFF, 1'b1, LEN_ERR_RST},
    '{SYNC_BYTE, 1'b0, NO_REPORT}, '{SYNC_BYTE, 1'b0, NO_REPORT},
    '{8'h03, 1'b0, NO_REPORT}, '{CODE_ATT, 1'b0, NO_REPORT},
    '{8'h64, 1'b0, NO_REPORT}, '{CODE_BANDS, 1'b0, NO_REPORT},
    '{8'h14, 1'b0, NO_REPORT}
  };

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_rx_byte = 8'h00;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  out_status;
  logic [7:0]  out_signal_quality;
  logic [7:0]  out_attention_level;
  logic [7:0]  out_meditation_level;
  logic [7:0]  out_blink_level;
  logic [2:0]  out_band_index;
  logic [23:0] out_band_power;
  logic        out_last;

  eeg_headset_packet_parser DUT (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_rx_byte           (in_rx_byte),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_status           (out_status),
    .out_signal_quality   (out_signal_quality),
    .out_attention_level  (out_attention_level),
    .out_meditation_level (out_meditation_level),
    .out_blink_level      (out_blink_level),
    .out_band_index       (out_band_index),
    .out_band_power       (out_band_power),
    .out_last             (out_last)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // parser shadow state
  parse_phase_t phase = HUNT_SYNC1;
  logic [7:0]   pay_mem [256];
  logic [7:0]   pay_cnt = 8'd0;
  logic [7:0]   pay_len = 8'd0;
  logic [7:0]   pay_sum = 8'd0;
  logic [7:0]   quality = 8'd200;
  logic [7:0]   attention = 8'd0;
  logic [7:0]   meditation = 8'd0;
  logic [7:0]   blink = 8'd0;
  logic [23:0]  band_pwr [NUM_BANDS] = '{default: 24'd0};

  band_report_t new_reports [NUM_BANDS];
  int           new_count;
  band_report_t expected_reports [$];
  logic [7:0]   burst [$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit hold_request = 1'b0;
  int mismatches = 0;
  int bytes_sent = 0;
  int reports_checked = 0;
  int good_packets = 0;
  int csum_errors = 0;
  int len_errors = 0;
  int quiet_cycles = 0;

  function automatic logic [7:0] pay_byte(int unsigned idx);
    if (idx >= pay_len) return 8'h00;
    return pay_mem[idx[7:0]];
  endfunction

  function automatic band_report_t make_report(logic [1:0] st, logic [2:0] band,
                                               logic [23:0] pwr, logic lst);
    band_report_t r;
    r.status     = st;
    r.quality    = quality;
    r.attention  = attention;
    r.meditation = meditation;
    r.blink      = blink;
    r.band       = band;
    r.power      = pwr;
    r.last       = lst;
    return r;
  endfunction

  task automatic walk_payload_items();
    int unsigned i;
    i = 0;
    while (i < pay_len) begin
      case (pay_byte(i))
        CODE_QUAL: begin
          i++;
          quality = pay_byte(i);
        end
        CODE_ATT: begin
          i++;
          attention = pay_byte(i);
        end
        CODE_MED: begin
          i++;
          meditation = pay_byte(i);
        end
        CODE_BLINK: begin
          i++;
          blink = pay_byte(i);
        end
        CODE_SKIP: i += 3;
        CODE_BANDS: begin
          // skip the item length byte, then eight big-endian 24-bit values
          i++;
          for (int b = 0; b < NUM_BANDS; b++) begin
            band_pwr[b] = {pay_byte(i + 1), pay_byte(i + 2), pay_byte(i + 3)};
            i += 3;
          end
        end
        default: ;
      endcase
      i++;
    end
  endtask

  task automatic advance_parser(input logic [7:0] rx);
    logic [7:0] csum_want;
    new_count = 0;
    case (phase)
      HUNT_SYNC2: phase = (rx == SYNC_BYTE) ? READ_LEN : HUNT_SYNC1;
      READ_LEN: begin
        phase = HUNT_SYNC1;
        if (rx > SYNC_BYTE) begin
          new_reports[0] = make_report(ST_LEN, 3'd0, 24'd0, 1'b1);
          new_count = 1;
        end else if (rx != SYNC_BYTE) begin
          pay_len = rx;
          pay_cnt = 8'd0;
          pay_sum = 8'd0;
          phase = (rx == 8'd0) ? READ_CSUM : READ_DATA;
        end
      end
      READ_DATA: begin
        pay_mem[pay_cnt] = rx;
        pay_sum = pay_sum + rx;
        pay_cnt = pay_cnt + 8'd1;
        if (pay_cnt >= pay_len) phase = READ_CSUM;
      end
      READ_CSUM: begin
        phase = HUNT_SYNC1;
        csum_want = CSUM_BASE - pay_sum;
        if (csum_want != rx) begin
          new_reports[0] = make_report(ST_CSUM, 3'd0, 24'd0, 1'b1);
          new_count = 1;
        end else begin
          walk_payload_items();
          for (int b = 0; b < NUM_BANDS; b++)
            new_reports[b] = make_report(ST_OK, 3'(b), band_pwr[b], b == NUM_BANDS - 1);
          new_count = NUM_BANDS;
        end
      end
      default: phase = (rx == SYNC_BYTE) ? HUNT_SYNC2 : HUNT_SYNC1;
    endcase
  endtask

  // Offer one byte, hold it until accepted, then record what it should cause.
  task automatic send_byte(input logic [7:0] rx, input logic has_exp,
                           input band_report_t exp);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= rx;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    bytes_sent++;
    advance_parser(rx);
    if (has_exp) expected_reports.push_back(exp);
    else for (int k = 0; k < new_count; k++) expected_reports.push_back(new_reports[k]);
  endtask

  task automatic drain_reports();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_reports.size() != 0);
  endtask

  // Mostly well-formed packets with random items; the rest is broken framing or a bad checksum.
  task automatic queue_packet();
    logic [7:0]  body [$];
    logic [7:0]  csum;
    int unsigned kind;
    int unsigned target;
    int unsigned keep;
    burst = {};
    kind = $urandom_range(99);
    if (kind < 6) begin
      burst = {SYNC_BYTE, SYNC_BYTE, 8'($urandom_range(170, 255))};
      return;
    end
    if (kind < 12) begin
      repeat ($urandom_range(1, 6)) burst.push_back(8'($urandom_range(255)));
      return;
    end
    if (kind < 16) begin
      burst = {SYNC_BYTE, 8'($urandom_range(0, 169))};
      return;
    end
    target = (kind < 18) ? $urandom_range(120, MAX_LEN) : $urandom_range(0, 30);
    while (body.size() < target) begin
      case ($urandom_range(6))
        0: body = {body, CODE_QUAL, 8'($urandom_range(255))};
        1: body = {body, CODE_ATT, 8'($urandom_range(255))};
        2: body = {body, CODE_MED, 8'($urandom_range(255))};
        3: body = {body, CODE_BLINK, 8'($urandom_range(255))};
        4: begin
          body.push_back(CODE_SKIP);
          repeat (3) body.push_back(8'($urandom_range(255)));
        end
        5: begin
          body = {body, CODE_BANDS, 8'h18};
          repeat (3 * NUM_BANDS) body.push_back(8'($urandom_range(255)));
        end
        default: body.push_back(8'($urandom_range(255)));
      endcase
    end
    // cut some packets mid-item so the walk runs past the payload end
    keep = (body.size() > target && $urandom_range(3) == 0) ? target : body.size();
    if (keep > MAX_LEN) keep = MAX_LEN;
    while (body.size() > keep) void'(body.pop_back());
    csum = CSUM_BASE;
    foreach (body[i]) csum = csum - body[i];
    if (kind < 28) csum = csum ^ 8'($urandom_range(1, 255));
    burst = {SYNC_BYTE, SYNC_BYTE, 8'(body.size())};
    foreach (body[i]) burst.push_back(body[i]);
    burst.push_back(csum);
  endtask

  // receiver: random stalls, or one long hold when asked
  always begin
    @(posedge clk);
    if (hold_request) begin
      out_stall <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk);
      hold_request = 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  task automatic flag_field(input string name, input logic [23:0] want,
                            input logic [23:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0h got %0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : report_check
    band_report_t got;
    band_report_t want;
    if (rst_n && out_valid && !out_stall) begin
      got = {out_status, out_signal_quality, out_attention_level, out_meditation_level,
             out_blink_level, out_band_index, out_band_power, out_last};
      if (expected_reports.size() == 0) begin
        $display("%0t: unexpected report, expected none got %h", $time, got);
        mismatches++;
      end else begin
        want = expected_reports.pop_front();
        reports_checked++;
        flag_field("status", 24'(want.status), 24'(got.status));
        flag_field("signal_quality", 24'(want.quality), 24'(got.quality));
        flag_field("attention_level", 24'(want.attention), 24'(got.attention));
        flag_field("meditation_level", 24'(want.meditation), 24'(got.meditation));
        flag_field("blink_level", 24'(want.blink), 24'(got.blink));
        flag_field("band_index", 24'(want.band), 24'(got.band));
        flag_field("band_power", want.power, got.power);
        flag_field("last", 24'(want.last), 24'(got.last));
        if (want.status == ST_CSUM) csum_errors++;
        else if (want.status == ST_LEN) len_errors++;
        else if (want.last) good_packets++;
      end
    end
  end

  // watchdog: no transaction on either side for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: timeout, %0d reports still pending", $time,
                 expected_reports.size());
        $display("Mismatches found");
        $finish;
      end
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle_pct = 27;
    recv_idle_pct = 79;
    foreach (DIRECTED[r]) send_byte(DIRECTED[r].rx, DIRECTED[r].has_exp, DIRECTED[r].exp);
    drain_reports();

    for (int stage = 0; stage < 3; stage++) begin
      send_idle_pct = (stage == 0) ? 27 : (stage == 1) ? 79 : 0;
      recv_idle_pct = (stage == 0) ? 79 : (stage == 1) ? 27 : 0;
      // long receiver hold while bytes keep coming: fill the block up
      if (stage == 2) hold_request = 1'b1;
      while (bytes_sent < STAGE_END[stage]) begin
        queue_packet();
        foreach (burst[i]) send_byte(burst[i], 1'b0, NO_REPORT);
      end
      drain_reports();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Drove %0d bytes; checked %0d reports: %0d good packets,", bytes_sent,
             reports_checked, good_packets);
    $display("%0d checksum errors, %0d length errors, under three stall mixes",
             csum_errors, len_errors);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
